// File: rtl/rle_dictionary_tile_decoder_core_macros.svh
// Assertion macros used by the checker file of the tile decoder.
`ifndef RLE_DICTIONARY_TILE_DECODER_CORE_MACROS_SVH
`define RLE_DICTIONARY_TILE_DECODER_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define RDTD_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("rdtd same-cycle check failed");

// Next-cycle implication, disabled while reset is held.
`define RDTD_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("rdtd next-cycle check failed");

`endif

// File: rtl/rdtd_pkg.sv
// Shared types and constants of the tile decoder.
package rdtd_pkg;

    typedef enum logic [1:0] {
        CMD_DICT_WRITE = 2'd0,
        CMD_START      = 2'd1,
        CMD_SOURCE     = 2'd2,
        CMD_UNUSED     = 2'd3
    } rdtd_cmd_t;

    localparam int RUN_FLAG_BIT  = 6;
    localparam int DICT_FLAG_BIT = 7;
    localparam logic [7:0] LOW6_MASK = 8'h3f;

    typedef struct packed {
        logic       is_start;
        logic       is_dict;
        logic [7:0] src_byte;
    } rdtd_item_t;

endpackage

// File: rtl/rdtd_dict_mem.sv
// Dictionary memory with one write port and one registered read port.
module rdtd_dict_mem import rdtd_pkg::*; #(
    parameter int DEPTH = 128
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [15:0]              wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [15:0]              rd_data
);

    logic [15:0] mem [DEPTH];
    logic [15:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/rdtd_expand.sv
// Record state, byte expansion and output register of the tile decoder.
module rdtd_expand import rdtd_pkg::*; #(
    parameter int LENGTH_BITS = 16
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   load,
    input  rdtd_item_t             load_item,
    input  logic [LENGTH_BITS-1:0] load_length,
    input  logic [15:0]            pair,
    output logic                   in_ready,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [7:0]             m_pixel,
    output logic [6:0]             m_run_length,
    output logic                   m_record_done
);

    logic                   busy_reg;
    logic                   phase_reg;
    rdtd_item_t             item_reg;
    logic [LENGTH_BITS-1:0] length_reg;
    logic [LENGTH_BITS-1:0] remaining_reg;
    logic [LENGTH_BITS-1:0] remaining_next;
    logic [7:0]             last_lit_reg;
    logic [7:0]             last_lit_next;
    logic                   valid_reg;
    logic [7:0]             pixel_reg;
    logic [6:0]             count_reg;
    logic                   done_reg;

    logic [7:0]             cur_byte;
    logic                   is_run;
    logic [6:0]             count_raw;
    logic [6:0]             count;
    logic [7:0]             value;
    logic                   step;
    logic                   emit;
    logic                   finish;

    always_comb begin
        if (item_reg.is_dict) begin
            cur_byte = phase_reg ? pair[7:0] : pair[15:8];
        end else begin
            cur_byte = item_reg.src_byte;
        end
        is_run    = cur_byte[RUN_FLAG_BIT];
        count_raw = {1'b0, cur_byte[5:0]} + 7'd1;
        if (is_run) begin
            if (LENGTH_BITS'(count_raw) > remaining_reg) begin
                count = remaining_reg[6:0];
            end else begin
                count = count_raw;
            end
            value         = last_lit_reg & LOW6_MASK;
            last_lit_next = last_lit_reg;
        end else begin
            count         = 7'd1;
            value         = cur_byte;
            last_lit_next = cur_byte;
        end
        remaining_next = remaining_reg - LENGTH_BITS'(count);
    end

    assign step   = busy_reg && (!valid_reg || m_ready);
    assign emit   = step && !item_reg.is_start && (remaining_reg != '0);
    assign finish = step && (item_reg.is_start || (remaining_reg == '0) ||
                             !item_reg.is_dict || phase_reg || (remaining_next == '0));
    assign in_ready = !busy_reg || finish;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg      <= 1'b0;
            phase_reg     <= 1'b0;
            remaining_reg <= '0;
            last_lit_reg  <= '0;
            valid_reg     <= 1'b0;
        end else begin
            if (load) begin
                busy_reg  <= 1'b1;
                phase_reg <= 1'b0;
            end else if (finish) begin
                busy_reg <= 1'b0;
            end else if (step) begin
                phase_reg <= 1'b1;
            end

            if (step && item_reg.is_start) begin
                remaining_reg <= length_reg;
                last_lit_reg  <= '0;
            end else if (emit) begin
                remaining_reg <= remaining_next;
                last_lit_reg  <= last_lit_next;
            end

            if (emit) begin
                valid_reg <= 1'b1;
            end else if (m_ready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            item_reg   <= load_item;
            length_reg <= load_length;
        end
        if (emit) begin
            pixel_reg <= value;
            count_reg <= count;
            done_reg  <= (remaining_next == '0);
        end
    end

    assign m_valid       = valid_reg;
    assign m_pixel       = pixel_reg;
    assign m_run_length  = count_reg;
    assign m_record_done = done_reg;

endmodule

// File: rtl/rle_dictionary_tile_decoder_core.sv
// Top level of the run-length and dictionary tile decoder.
//
// The input channel carries commands: a dictionary write stores a byte pair
// in the 128-entry dictionary, a record start sets the record length, and a
// source byte is decoded into up to two result beats. Each result beat
// carries a pixel value, a run length of 1 to 64 and a record done flag.
// A dictionary code reads the dictionary memory when it is accepted; the
// registered pair is ready once the code is in the expansion stage, which
// then produces the results into an output register. The first result of
// a byte passes through the item register of the expansion stage and then
// the output register. A dictionary code emits up to two results, one after
// the other, from the one expansion stage. Dictionary writes give no result.
// Reset clears the record state and the last literal; the dictionary holds
// no defined data until written. When the receiver stalls, the output
// register holds its beat, the expansion stage waits, and the input channel
// stops taking beats once that stage is full.
module rle_dictionary_tile_decoder_core import rdtd_pkg::*; #(
    parameter int DICT_ENTRIES = 128,
    parameter int LENGTH_BITS  = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_command,
    input  logic [6:0]  s_dict_index,
    input  logic [15:0] s_dict_pair,
    input  logic [15:0] s_record_length,
    input  logic [7:0]  s_source_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_pixel,
    output logic [6:0]  m_run_length,
    output logic        m_record_done
);

    localparam int DICT_AW = $clog2(DICT_ENTRIES);

    logic       accept;
    rdtd_cmd_t  cmd;
    logic       load;
    rdtd_item_t item;
    logic [15:0] pair;

    assign accept = s_valid && s_ready;
    assign cmd    = rdtd_cmd_t'(s_command);
    assign load   = accept && ((cmd == CMD_START) || (cmd == CMD_SOURCE));

    assign item.is_start = (cmd == CMD_START);
    assign item.is_dict  = s_source_byte[DICT_FLAG_BIT];
    assign item.src_byte = s_source_byte;

    rdtd_dict_mem #(
        .DEPTH(DICT_ENTRIES)
    ) u_dict_mem (
        .aclk    (aclk),
        .wr_en   (accept && (cmd == CMD_DICT_WRITE)),
        .wr_addr (s_dict_index[DICT_AW-1:0]),
        .wr_data (s_dict_pair),
        .rd_en   (accept && (cmd == CMD_SOURCE) && s_source_byte[DICT_FLAG_BIT]),
        .rd_addr (s_source_byte[DICT_AW-1:0]),
        .rd_data (pair)
    );

    rdtd_expand #(
        .LENGTH_BITS(LENGTH_BITS)
    ) u_expand (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .load          (load),
        .load_item     (item),
        .load_length   (LENGTH_BITS'(s_record_length)),
        .pair          (pair),
        .in_ready      (s_ready),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_pixel       (m_pixel),
        .m_run_length  (m_run_length),
        .m_record_done (m_record_done)
    );

endmodule

// File: rtl/rdtd_checker.sv
// Port-level assertion checker of the tile decoder and its bind.
`include "rle_dictionary_tile_decoder_core_macros.svh"

module rdtd_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_valid,
    input logic        m_ready,
    input logic [7:0]  m_pixel,
    input logic [6:0]  m_run_length,
    input logic        m_record_done
);

    logic        out_stall;
    logic [16:0] out_beat;
    logic        run_in_range;
    logic        long_run;

    assign out_stall    = m_valid && !m_ready;
    assign out_beat     = {m_valid, m_pixel, m_run_length, m_record_done};
    assign run_in_range = (m_run_length != 7'd0) && (m_run_length <= 7'd64);
    assign long_run     = m_valid && (m_run_length > 7'd1);

    `RDTD_ASSERT_NEXT(a_out_hold, aclk, aresetn, out_stall, $stable(out_beat))
    `RDTD_ASSERT_NOW(a_run_range, aclk, aresetn, m_valid, run_in_range)
    `RDTD_ASSERT_NOW(a_run_six_bits, aclk, aresetn, long_run, m_pixel[7:6] == 2'b00)

endmodule

bind rle_dictionary_tile_decoder_core rdtd_checker u_rdtd_checker (.*);

// File: bench/rle_dictionary_tile_decoder_core_tb.sv
// Self-checking testbench for the run-length and dictionary tile decoder core.
`timescale 1ns / 1ps

module rle_dictionary_tile_decoder_core_tb;
    import rdtd_pkg::*;

    typedef struct {
        rdtd_cmd_t   cmd;
        logic [6:0]  idx;
        logic [15:0] pair;
        logic [15:0] len;
        logic [7:0]  src;
    } decoder_beat_t;

    typedef struct {
        logic [7:0] pixel;
        logic [6:0] run_length;
        logic       record_done;
    } pixel_run_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [1:0]  s_command = CMD_UNUSED;
    logic [6:0]  s_dict_index = '0;
    logic [15:0] s_dict_pair = '0;
    logic [15:0] s_record_length = '0;
    logic [7:0]  s_source_byte = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [7:0]  m_pixel;
    logic [6:0]  m_run_length;
    logic        m_record_done;

    decoder_beat_t beat_queue[$];
    pixel_run_t    pixel_runs[$];

    logic [15:0] dict_mem[128];
    logic [15:0] bytes_left = '0;
    logic [7:0]  last_lit = '0;

    logic        dict_loaded[128];
    int          loaded_codes[$];

    int          burst_left = 0;
    int          gap_left = 0;
    logic [15:0] ready_pattern = 16'hffff;
    int          pattern_age = 0;
    int          errors = 0;

    rle_dictionary_tile_decoder_core uut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_command      (s_command),
        .s_dict_index   (s_dict_index),
        .s_dict_pair    (s_dict_pair),
        .s_record_length(s_record_length),
        .s_source_byte  (s_source_byte),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_pixel        (m_pixel),
        .m_run_length   (m_run_length),
        .m_record_done  (m_record_done)
    );

    always #4 aclk = ~aclk;

    function automatic void expand_byte(input logic [7:0] b);
        pixel_run_t  r;
        logic [15:0] cnt;
        if (b[RUN_FLAG_BIT]) begin
            cnt = {8'h00, b & LOW6_MASK} + 16'd1;
            if (cnt > bytes_left) cnt = bytes_left;
            r.pixel = last_lit & LOW6_MASK;
        end else begin
            cnt = 16'd1;
            r.pixel = b;
            last_lit = b;
        end
        bytes_left = bytes_left - cnt;
        r.run_length = cnt[6:0];
        r.record_done = (bytes_left == 16'd0);
        pixel_runs.push_back(r);
    endfunction

    function automatic void predict_decode(input rdtd_cmd_t cmd, input logic [6:0] idx,
                                           input logic [15:0] pair, input logic [15:0] len,
                                           input logic [7:0] src);
        logic [15:0] entry;
        case (cmd)
            CMD_DICT_WRITE: dict_mem[idx] = pair;
            CMD_START: begin
                bytes_left = len;
                last_lit = 8'h00;
            end
            CMD_SOURCE: begin
                if (bytes_left != 16'd0) begin
                    if (src[DICT_FLAG_BIT]) begin
                        entry = dict_mem[src[6:0]];
                        expand_byte(entry[15:8]);
                        if (bytes_left != 16'd0) expand_byte(entry[7:0]);
                    end else begin
                        expand_byte(src);
                    end
                end
            end
            default: ;
        endcase
    endfunction

    // Fields that the command does not use carry random values.
    function automatic void queue_beat(input rdtd_cmd_t cmd, input logic [15:0] a,
                                       input logic [15:0] b);
        decoder_beat_t t;
        t.cmd = cmd;
        t.idx = 7'($urandom());
        t.pair = 16'($urandom());
        t.len = 16'($urandom());
        t.src = 8'($urandom());
        case (cmd)
            CMD_DICT_WRITE: begin
                t.idx = a[6:0];
                t.pair = b;
                if (!dict_loaded[a[6:0]]) begin
                    dict_loaded[a[6:0]] = 1'b1;
                    loaded_codes.push_back(int'(a[6:0]));
                end
            end
            CMD_START: t.len = a;
            CMD_SOURCE: t.src = a[7:0];
            default: ;
        endcase
        beat_queue.push_back(t);
    endfunction

    function automatic logic [7:0] pick_source_byte();
        int k;
        k = $urandom_range(0, 99);
        if (k < 35)
            return {1'b1, 7'(loaded_codes[$urandom_range(0, loaded_codes.size() - 1)])};
        else if (k < 65)
            return {2'b00, 6'($urandom())};
        else
            return {2'b01, 6'($urandom())};
    endfunction

    function automatic void build_stimulus();
        int          produced;
        int          r;
        int          n;
        logic [15:0] len;
        foreach (dict_loaded[i]) dict_loaded[i] = 1'b0;
        queue_beat(CMD_UNUSED, 16'hffff, 16'hffff);
        queue_beat(CMD_SOURCE, 16'h0005, 16'h0000);
        queue_beat(CMD_DICT_WRITE, 16'h007f, 16'h8a41);
        queue_beat(CMD_DICT_WRITE, 16'h0000, 16'h1243);
        queue_beat(CMD_DICT_WRITE, 16'h0055, 16'hc07f);
        queue_beat(CMD_START, 16'hffff, 16'h0000);
        queue_beat(CMD_SOURCE, 16'h0045, 16'h0000);
        queue_beat(CMD_SOURCE, 16'h0000, 16'h0000);
        queue_beat(CMD_SOURCE, 16'h003f, 16'h0000);
        queue_beat(CMD_SOURCE, 16'h007f, 16'h0000);
        queue_beat(CMD_SOURCE, 16'h0040, 16'h0000);
        queue_beat(CMD_SOURCE, 16'h00ff, 16'h0000);
        queue_beat(CMD_SOURCE, 16'h00d5, 16'h0000);
        queue_beat(CMD_START, 16'h0000, 16'h0000);
        queue_beat(CMD_SOURCE, 16'h0011, 16'h0000);
        queue_beat(CMD_START, 16'h0003, 16'h0000);
        queue_beat(CMD_SOURCE, 16'h0045, 16'h0000);
        queue_beat(CMD_SOURCE, 16'h0012, 16'h0000);
        queue_beat(CMD_START, 16'h0001, 16'h0000);
        queue_beat(CMD_SOURCE, 16'h0080, 16'h0000);
        queue_beat(CMD_START, 16'h0003, 16'h0000);
        queue_beat(CMD_SOURCE, 16'h0080, 16'h0000);
        queue_beat(CMD_START, 16'h8000, 16'h0000);
        queue_beat(CMD_SOURCE, 16'h00ff, 16'h0000);
        queue_beat(CMD_SOURCE, 16'h0055, 16'h0000);
        for (int i = 0; i < 12; i++)
            queue_beat(CMD_DICT_WRITE, 16'($urandom()), 16'($urandom()));
        produced = 0;
        while (produced < 1100) begin
            r = $urandom_range(0, 99);
            if (r < 8) begin
                queue_beat(CMD_DICT_WRITE, 16'($urandom()), 16'($urandom()));
            end else if (r < 11) begin
                queue_beat(CMD_UNUSED, 16'($urandom()), 16'($urandom()));
            end else if (r < 13) begin
                queue_beat(CMD_SOURCE, {8'h00, pick_source_byte()}, 16'h0000);
            end else begin
                r = $urandom_range(0, 99);
                if (r < 10) len = 16'd0;
                else if (r < 18) len = 16'($urandom_range(121, 65535));
                else len = 16'($urandom_range(1, 120));
                queue_beat(CMD_START, len, 16'h0000);
                n = $urandom_range(1, 24);
                for (int i = 0; i < n; i++)
                    queue_beat(CMD_SOURCE, {8'h00, pick_source_byte()}, 16'h0000);
                produced += n;
            end
        end
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            if (s_valid)
                predict_decode(rdtd_cmd_t'(s_command), s_dict_index, s_dict_pair,
                               s_record_length, s_source_byte);
            if (gap_left != 0 || beat_queue.size() == 0) begin
                s_valid <= 1'b0;
                if (gap_left != 0) gap_left <= gap_left - 1;
            end else begin
                s_valid <= 1'b1;
                s_command <= beat_queue[0].cmd;
                s_dict_index <= beat_queue[0].idx;
                s_dict_pair <= beat_queue[0].pair;
                s_record_length <= beat_queue[0].len;
                s_source_byte <= beat_queue[0].src;
                void'(beat_queue.pop_front());
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 32);
                    gap_left <= ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 6);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (pixel_runs.size() == 0) begin
                    $display("%0t: unexpected beat, expected none, actual pixel=%h run=%0d done=%b",
                             $time, m_pixel, m_run_length, m_record_done);
                    errors++;
                end else begin
                    if (m_pixel !== pixel_runs[0].pixel
                            || m_run_length !== pixel_runs[0].run_length
                            || m_record_done !== pixel_runs[0].record_done) begin
                        $display("%0t: mismatch, expected pixel=%h run=%0d done=%b, actual pixel=%h run=%0d done=%b",
                                 $time, pixel_runs[0].pixel, pixel_runs[0].run_length,
                                 pixel_runs[0].record_done, m_pixel, m_run_length,
                                 m_record_done);
                        errors++;
                    end
                    void'(pixel_runs.pop_front());
                end
            end
            m_ready <= ready_pattern[0];
            if (pattern_age == 63) begin
                pattern_age <= 0;
                if ($urandom_range(0, 3) == 0) begin
                    ready_pattern <= 16'hffff;
                end else begin
                    ready_pattern <= 16'($urandom()) | 16'h0001;
                end
            end else begin
                pattern_age <= pattern_age + 1;
                ready_pattern <= {ready_pattern[0], ready_pattern[15:1]};
            end
        end
    end

    initial begin
        build_stimulus();
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        while (beat_queue.size() != 0 || s_valid) @(posedge aclk);
        while (pixel_runs.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (errors == 0 && pixel_runs.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    initial begin
        #5000000;
        $display("FAILURE");
        $finish;
    end

endmodule
